// File: rtl/pcwpm_pkg.sv
// ----------------------------------------------------------------------------
// pcwpm_pkg
// shared types and constants of the pseudocolor window palette map
// ----------------------------------------------------------------------------
package pcwpm_pkg;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int GAM_W      = 17;
  localparam int COLOR_W    = 32;
  localparam int PIDX_W     = 8;
  localparam int OUT_W      = 48;
  localparam int OUT_PAD    = OUT_W - COLOR_W - PIDX_W - 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int CMP_W      = 13;
  localparam int ONE_Q16    = 65536;
  localparam int HALF_Q16   = 32768;

  typedef enum logic [1:0] {
    OP_MAP   = 2'd0,
    OP_PAL   = 2'd1,
    OP_GAMMA = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_MIN   = 3'd0,
    REG_INVERSE_SPAN = 3'd1,
    REG_FLAT_WINDOW  = 3'd2,
    REG_BRIGHTNESS   = 3'd3,
    REG_CONTRAST     = 3'd4,
    REG_ADJUST_EN    = 3'd5,
    REG_GAMMA_EN     = 3'd6,
    REG_PALETTE_LAST = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] window_min;
    logic [23:0] inverse_span;
    logic        flat_window;
    logic [20:0] brightness_offset;
    logic [23:0] contrast_gain;
    logic        adjust_enable;
    logic        gamma_enable;
    logic [7:0]  palette_last;
  } cfg_t;

  // request leaving the normalize / gamma half
  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [IDX_W-1:0]   idx;
    logic [VAL_W-1:0]   val;
    logic signed [37:0] n36;
    logic signed [18:0] n_lin;
    logic [GAM_W-1:0]   gam;
  } front_t;

endpackage

// File: rtl/pcwpm_ram.sv
// ----------------------------------------------------------------------------
// pcwpm_ram
// single port synchronous ram with registered read
// ----------------------------------------------------------------------------
module pcwpm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/pcwpm_front.sv
// ----------------------------------------------------------------------------
// pcwpm_front
// window normalize, saturation, gamma curve lookup and gamma curve writes
// ----------------------------------------------------------------------------
module pcwpm_front import pcwpm_pkg::*; #(
  parameter int GAMMA_DEPTH = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   in_vld,
  input  op_t                    in_op,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic [IDX_W-1:0]       in_idx,
  input  logic [VAL_W-1:0]       in_val,
  input  cfg_t                   cfg,
  output front_t                 fr
);

  localparam int SW  = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;
  localparam int DW  = SW + 1;
  localparam int NW  = DW + 25;
  localparam int GAW = $clog2(GAMMA_DEPTH);
  localparam int GPW = GAM_W + GAW;
  localparam logic [GAW-1:0] GMAX = GAW'(GAMMA_DEPTH - 1);
  localparam logic signed [NW-1:0] N_ONE = NW'(ONE_Q16);
  localparam logic signed [NW-1:0] L36 = NW'(64'sd68719476736);
  localparam logic signed [NW-1:0] L17 = NW'(64'sd131072);

  logic vld1_r, vld2_r, vld3_r, vld4_r;
  op_t  op1_r, op2_r, op3_r, op4_r;
  logic [IDX_W-1:0] idx1_r, idx2_r, idx3_r, idx4_r;
  logic [VAL_W-1:0] val1_r, val2_r, val3_r, val4_r;

  logic signed [DW-1:0]  d1_nxt, d1_r;
  logic signed [24:0]    span_s;
  logic signed [NW-1:0]  n2_nxt, n2_r;
  logic [GAM_W-1:0]      c_sel;
  logic [GPW-1:0]        gprod3_nxt, gprod3_r, gsum;
  logic signed [37:0]    n36_3_nxt, n36_3_r, n36_4_r;
  logic signed [18:0]    nlin3_nxt, nlin3_r, nlin4_r;
  logic [GAW-1:0]        g_addr;
  logic [GAW+IDX_W-1:0]  idx_wide;
  logic                  g_we;
  logic [GAM_W-1:0]      g_q;

  assign d1_nxt = $signed({{(DW-SAMPLE_BITS){in_sample[SAMPLE_BITS-1]}}, in_sample})
                - $signed({{(DW-16){cfg.window_min[15]}}, cfg.window_min});
  assign span_s = $signed({1'b0, cfg.inverse_span});
  assign n2_nxt = d1_r * span_s;

  always_comb begin
    priority if (n2_r < 0) begin
      c_sel = '0;
    end else if (n2_r > N_ONE) begin
      c_sel = GAM_W'(ONE_Q16);
    end else begin
      c_sel = n2_r[GAM_W-1:0];
    end
    gprod3_nxt = GPW'(c_sel) * GPW'(GMAX);

    priority if (n2_r > L36) begin
      n36_3_nxt = L36[37:0];
    end else if (n2_r < -L36) begin
      n36_3_nxt = -38'sd68719476736;
    end else begin
      n36_3_nxt = n2_r[37:0];
    end

    priority if (n2_r > L17) begin
      nlin3_nxt = L17[18:0];
    end else if (n2_r < -L17) begin
      nlin3_nxt = -19'sd131072;
    end else begin
      nlin3_nxt = n2_r[18:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else if (en) begin
      vld1_r <= in_vld;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r    <= in_op;
      idx1_r   <= in_idx;
      val1_r   <= in_val;
      d1_r     <= d1_nxt;
      op2_r    <= op1_r;
      idx2_r   <= idx1_r;
      val2_r   <= val1_r;
      n2_r     <= n2_nxt;
      op3_r    <= op2_r;
      idx3_r   <= idx2_r;
      val3_r   <= val2_r;
      gprod3_r <= gprod3_nxt;
      n36_3_r  <= n36_3_nxt;
      nlin3_r  <= nlin3_nxt;
      op4_r    <= op3_r;
      idx4_r   <= idx3_r;
      val4_r   <= val3_r;
      n36_4_r  <= n36_3_r;
      nlin4_r  <= nlin3_r;
    end
  end

  // round half up into the curve index
  assign gsum     = gprod3_r + GPW'(HALF_Q16);
  assign idx_wide = (GAW+IDX_W)'(idx3_r);
  assign g_addr   = (op3_r == OP_MAP) ? gsum[GAW+15:16] : idx_wide[GAW-1:0];
  assign g_we     = en && vld3_r && (op3_r == OP_GAMMA)
                 && (CMP_W'(idx3_r) < CMP_W'(GAMMA_DEPTH));

  pcwpm_ram #(
    .WIDTH (GAM_W),
    .DEPTH (GAMMA_DEPTH)
  ) u_gamma_ram (
    .clk   (clk),
    .we    (g_we),
    .re    (en),
    .addr  (g_addr),
    .wdata (val3_r[GAM_W-1:0]),
    .rdata (g_q)
  );

  always_comb begin
    fr.vld   = vld4_r;
    fr.op    = op4_r;
    fr.idx   = idx4_r;
    fr.val   = val4_r;
    fr.n36   = n36_4_r;
    fr.n_lin = nlin4_r;
    fr.gam   = g_q;
  end

endmodule

// File: rtl/pcwpm_back.sv
// ----------------------------------------------------------------------------
// pcwpm_back
// brightness and contrast, palette scaling, round, clamp, palette read and palette writes
// ----------------------------------------------------------------------------
module pcwpm_back import pcwpm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  front_t             fr,
  input  cfg_t               cfg,
  output logic               out_vld,
  output logic [COLOR_W-1:0] color,
  output logic [PIDX_W-1:0]  pidx,
  output logic               clamped
);

  localparam int PAW = $clog2(PALETTE_DEPTH);
  localparam logic [CMP_W-1:0] PMAX = CMP_W'(PALETTE_DEPTH - 1);

  logic vld5_r, vld6_r, vld7_r, vld8_r, vld9_r;
  op_t  op5_r, op6_r, op7_r, op8_r, op9_r;
  logic [IDX_W-1:0] idx5_r, idx6_r, idx7_r, idx8_r;
  logic [VAL_W-1:0] val5_r, val6_r, val7_r, val8_r;

  logic signed [37:0] t_sel;
  logic signed [38:0] t_sum;
  logic signed [34:0] t5_nxt, t5_r;
  logic signed [18:0] nlin5_r;
  logic signed [47:0] plo6_nxt, plo6_r, phi6_nxt, phi6_r;
  logic signed [34:0] vlin6_nxt, vlin6_r;
  logic signed [60:0] v_sum;
  logic signed [34:0] v7_nxt, v7_r;
  logic [PIDX_W-1:0]  last_c;
  logic signed [43:0] m8_nxt, m8_r;
  logic signed [44:0] q_sum;
  logic signed [12:0] q;
  logic [PIDX_W-1:0]  r9_nxt, r9_r;
  logic               cl9_nxt, cl9_r;
  logic [PAW+PIDX_W-1:0] r_wide;
  logic [PAW+IDX_W-1:0]  idx_wide;
  logic [PAW-1:0]     p_addr;
  logic               p_we;

  assign last_c = (CMP_W'(cfg.palette_last) > PMAX) ? PMAX[PIDX_W-1:0] : cfg.palette_last;

  always_comb begin
    t_sel = cfg.gamma_enable ? $signed({21'b0, fr.gam}) : fr.n36;
    t_sum = t_sel + $signed(cfg.brightness_offset);
    // beyond this bound the palette index is the same as at the bound
    priority if (t_sum > 39'sd8589934592) begin
      t5_nxt = 35'sd8589934592;
    end else if (t_sum < -39'sd8589934592) begin
      t5_nxt = -35'sd8589934592;
    end else begin
      t5_nxt = t_sum[34:0];
    end
  end

  assign plo6_nxt  = t5_r * $signed({1'b0, cfg.contrast_gain[11:0]});
  assign phi6_nxt  = t5_r * $signed({1'b0, cfg.contrast_gain[23:12]});
  assign vlin6_nxt = {nlin5_r, 16'b0};

  always_comb begin
    v_sum = (phi6_r <<< 12) + plo6_r;
    if (!cfg.adjust_enable) begin
      v7_nxt = vlin6_r;
    end else if (v_sum > 61'sd8589934592) begin
      v7_nxt = 35'sd8589934592;
    end else if (v_sum < -61'sd8589934592) begin
      v7_nxt = -35'sd8589934592;
    end else begin
      v7_nxt = v_sum[34:0];
    end
  end

  assign m8_nxt = v7_r * $signed({1'b0, last_c});

  always_comb begin
    q_sum = m8_r + 45'sd2147483648;
    q     = q_sum[44:32];
    priority if (cfg.flat_window) begin
      r9_nxt  = '0;
      cl9_nxt = 1'b0;
    end else if (q < 0) begin
      r9_nxt  = '0;
      cl9_nxt = 1'b1;
    end else if (q > $signed({5'b0, last_c})) begin
      r9_nxt  = last_c;
      cl9_nxt = 1'b1;
    end else begin
      r9_nxt  = q[PIDX_W-1:0];
      cl9_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld5_r <= 1'b0;
      vld6_r <= 1'b0;
      vld7_r <= 1'b0;
      vld8_r <= 1'b0;
      vld9_r <= 1'b0;
    end else if (en) begin
      vld5_r <= fr.vld;
      vld6_r <= vld5_r;
      vld7_r <= vld6_r;
      vld8_r <= vld7_r;
      vld9_r <= vld8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op5_r   <= fr.op;
      idx5_r  <= fr.idx;
      val5_r  <= fr.val;
      t5_r    <= t5_nxt;
      nlin5_r <= fr.n_lin;
      op6_r   <= op5_r;
      idx6_r  <= idx5_r;
      val6_r  <= val5_r;
      plo6_r  <= plo6_nxt;
      phi6_r  <= phi6_nxt;
      vlin6_r <= vlin6_nxt;
      op7_r   <= op6_r;
      idx7_r  <= idx6_r;
      val7_r  <= val6_r;
      v7_r    <= v7_nxt;
      op8_r   <= op7_r;
      idx8_r  <= idx7_r;
      val8_r  <= val7_r;
      m8_r    <= m8_nxt;
      op9_r   <= op8_r;
      r9_r    <= r9_nxt;
      cl9_r   <= cl9_nxt;
    end
  end

  assign r_wide   = (PAW+PIDX_W)'(r9_nxt);
  assign idx_wide = (PAW+IDX_W)'(idx8_r);
  assign p_addr   = (op8_r == OP_MAP) ? r_wide[PAW-1:0] : idx_wide[PAW-1:0];
  assign p_we     = en && vld8_r && (op8_r == OP_PAL)
                 && (CMP_W'(idx8_r) < CMP_W'(PALETTE_DEPTH));

  pcwpm_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette_ram (
    .clk   (clk),
    .we    (p_we),
    .re    (en),
    .addr  (p_addr),
    .wdata (val8_r),
    .rdata (color)
  );

  assign out_vld = vld9_r && (op9_r == OP_MAP);
  assign pidx    = r9_r;
  assign clamped = cl9_r;

endmodule

// File: rtl/pseudocolor_window_palette_map.sv
// ----------------------------------------------------------------------------
// pseudocolor_window_palette_map
// window/level normalize, optional gamma, brightness and contrast, palette lookup
//
// a map request passes stages 1 to 9 and shows on out_tvalid from stage 9
// throughput: one request per cycle; the nine-stage pipeline stalls as a whole
//   only while a result is held on the output and out_tready is low
// write requests load the gamma ram at stage 3 and the palette ram at stage 8,
//   the same stages where map requests read them, so request order is kept
// reset: synchronous, clears valid bits and config; the rams hold no reset state
// ----------------------------------------------------------------------------
module pseudocolor_window_palette_map import pcwpm_pkg::*; #(
  parameter int PALETTE_DEPTH = 256,
  parameter int GAMMA_DEPTH   = 1024,
  parameter int SAMPLE_BITS   = 16,
  localparam int IN_W = ((SAMPLE_BITS + IDX_W + VAL_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // sample, entry_index, entry_value, zero pad
  input  logic [1:0]            in_tuser,   // operation
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_W-1:0]      out_tdata,  // color, palette_index, was_clamped, zero pad
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  logic   en;
  front_t fr;
  logic [COLOR_W-1:0] color;
  logic [PIDX_W-1:0]  pidx;
  logic               clamped;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.window_min        <= '0;
      cfg_r.inverse_span      <= 24'd2;
      cfg_r.flat_window       <= 1'b0;
      cfg_r.brightness_offset <= '0;
      cfg_r.contrast_gain     <= 24'd65536;
      cfg_r.adjust_enable     <= 1'b0;
      cfg_r.gamma_enable      <= 1'b0;
      cfg_r.palette_last      <= 8'd255;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_WINDOW_MIN:   cfg_r.window_min        <= cfg_data[15:0];
        REG_INVERSE_SPAN: cfg_r.inverse_span      <= cfg_data[23:0];
        REG_FLAT_WINDOW:  cfg_r.flat_window       <= cfg_data[0];
        REG_BRIGHTNESS:   cfg_r.brightness_offset <= cfg_data[20:0];
        REG_CONTRAST:     cfg_r.contrast_gain     <= cfg_data[23:0];
        REG_ADJUST_EN:    cfg_r.adjust_enable     <= cfg_data[0];
        REG_GAMMA_EN:     cfg_r.gamma_enable      <= cfg_data[0];
        REG_PALETTE_LAST: cfg_r.palette_last      <= cfg_data[7:0];
        default:          cfg_r                   <= cfg_r;
      endcase
    end
  end

  // pipeline advances unless a result is held on the output
  assign en        = !(out_tvalid && !out_tready);
  assign in_tready = en;

  pcwpm_front #(
    .GAMMA_DEPTH (GAMMA_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid && in_tready),
    .in_op     (op_t'(in_tuser)),
    .in_sample (in_tdata[SAMPLE_BITS-1:0]),
    .in_idx    (in_tdata[SAMPLE_BITS+IDX_W-1:SAMPLE_BITS]),
    .in_val    (in_tdata[SAMPLE_BITS+IDX_W+VAL_W-1:SAMPLE_BITS+IDX_W]),
    .cfg       (cfg_r),
    .fr        (fr)
  );

  pcwpm_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .fr      (fr),
    .cfg     (cfg_r),
    .out_vld (out_tvalid),
    .color   (color),
    .pidx    (pidx),
    .clamped (clamped)
  );

  assign out_tdata = {{OUT_PAD{1'b0}}, clamped, pidx, color};

endmodule

// File: rtl/pcwpm_check.sv
// ----------------------------------------------------------------------------
// pcwpm_check
// port level checks of the pseudocolor window palette map
// ----------------------------------------------------------------------------
module pcwpm_check import pcwpm_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // no result is invented out of reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // input side stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without a held result");

  // a held result keeps its value
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("held result changed or dropped");

  // the input side is ready whenever the output is ready
  a_ready_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output ready");

endmodule

bind pseudocolor_window_palette_map pcwpm_check u_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/tb_pseudocolor_window_palette_map.sv
// ----------------------------------------------------------------------------
// tb_pseudocolor_window_palette_map
// self-checking bench for the window/level palette map
//
// Loads the whole palette and gamma curve, then runs phases. Each later phase
// writes all eight registers while the pipeline is empty and streams a batch
// of requests. A short hand-picked set covers saturation, flat window, gamma
// clamping, half-up rounding, a single-entry palette, ignored writes and the
// unused opcode. The random phases follow: mostly samples inside a sensible
// window, plus table rewrites and noise. Every accepted map request is scored
// in a bit-true Q.16 predictor, and each result is compared field by field
// in order. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_pseudocolor_window_palette_map;
  import pcwpm_pkg::*;

  localparam int PAL_DEPTH     = 256;
  localparam int GAM_DEPTH     = 1024;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_ITEMS   = 40;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]       op;
    logic [15:0]      sample;
    logic [IDX_W-1:0] eidx;
    logic [VAL_W-1:0] eval;
  } req_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [PIDX_W-1:0]  pidx;
    logic               clamped;
  } pixel_exp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [63:0]           in_tdata = '0;
  logic [1:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pseudocolor_window_palette_map dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  cfg_t               map_cfg;
  logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
  logic [GAM_W-1:0]   gam_mem [GAM_DEPTH];
  req_t               req_backlog [$];
  pixel_exp_t         colors_due [$];
  req_t               cur_req;
  int                 in_hold = 0;
  int                 out_hold = 0;
  int                 in_gap_max = 0;
  int                 out_gap_max = 0;
  int                 err_count = 0;

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic longint clip(longint x, longint lim);
    if (x > lim) return lim;
    if (x < -lim) return -lim;
    return x;
  endfunction

  function automatic pixel_exp_t shade_sample(logic [15:0] smp);
    pixel_exp_t px;
    longint     last, n, t, v, r, c, gi;
    last = longint'(map_cfg.palette_last);
    px.color = pal_mem[0];
    px.pidx = '0;
    px.clamped = 1'b0;
    if (map_cfg.flat_window) return px;
    n = (longint'($signed(smp)) - longint'($signed(map_cfg.window_min)))
        * longint'(map_cfg.inverse_span);
    if (map_cfg.adjust_enable) begin
      if (map_cfg.gamma_enable) begin
        c = (n < 0) ? 0 : ((n > ONE_Q16) ? ONE_Q16 : n);
        gi = (c * (GAM_DEPTH - 1) + HALF_Q16) >>> 16;
        t = longint'(gam_mem[int'(gi)]);
      end else begin
        t = clip(n, longint'(1) << 36);
      end
      t += longint'($signed(map_cfg.brightness_offset));
      v = clip(t * longint'(map_cfg.contrast_gain), longint'(1) << 44);
    end else begin
      v = clip(n, longint'(1) << 28) * ONE_Q16;
    end
    r = (v * last + (longint'(1) << 31)) >>> 32;
    if (r < 0) begin
      r = 0;
      px.clamped = 1'b1;
    end else if (r > last) begin
      r = last;
      px.clamped = 1'b1;
    end
    px.color = pal_mem[int'(r)];
    px.pidx = 8'(r);
    return px;
  endfunction

  function automatic void track_request(req_t q);
    case (q.op)
      OP_MAP:   colors_due.push_back(shade_sample(q.sample));
      OP_PAL:   if (q.eidx < PAL_DEPTH) pal_mem[q.eidx] = q.eval;
      OP_GAMMA: gam_mem[q.eidx] = q.eval[GAM_W-1:0];
      default: ;
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin : drive_in
    int gap;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_hold <= 0;
    end else if (in_tvalid && in_tready) begin
      track_request(cur_req);
      gap = $urandom_range(0, in_gap_max);
      if (gap == 0 && req_backlog.size() != 0) begin
        cur_req = req_backlog.pop_front();
        in_tdata <= {6'b0, cur_req.eval, cur_req.eidx, cur_req.sample};
        in_tuser <= cur_req.op;
      end else begin
        in_tvalid <= 1'b0;
        in_hold <= gap;
      end
    end else if (!in_tvalid) begin
      if (in_hold != 0) begin
        in_hold <= in_hold - 1;
      end else if (req_backlog.size() != 0) begin
        cur_req = req_backlog.pop_front();
        in_tdata <= {6'b0, cur_req.eval, cur_req.eidx, cur_req.sample};
        in_tuser <= cur_req.op;
        in_tvalid <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_out
    int         stall;
    pixel_exp_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_hold <= 0;
    end else if (out_tvalid && out_tready) begin
      if (colors_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %h", out_tdata));
      end else begin
        e = colors_due.pop_front();
        if (out_tdata[31:0] !== e.color)
          flag_mismatch($sformatf("color %h, want %h", out_tdata[31:0], e.color));
        if (out_tdata[39:32] !== e.pidx)
          flag_mismatch($sformatf("palette_index %0d, want %0d", out_tdata[39:32], e.pidx));
        if (out_tdata[40] !== e.clamped)
          flag_mismatch($sformatf("was_clamped %b, want %b", out_tdata[40], e.clamped));
      end
      stall = $urandom_range(0, out_gap_max);
      if (stall != 0) begin
        out_tready <= 1'b0;
        out_hold <= stall;
      end
    end else if (!out_tready) begin
      if (out_hold != 0) out_hold <= out_hold - 1;
      else out_tready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // upper data bits carry junk, only the register width counts
  task automatic load_config(cfg_t c);
    logic [CFG_DATA_W-1:0] d;
    for (int k = 0; k < 8; k++) begin
      d = CFG_DATA_W'($urandom);
      case (cfg_reg_t'(k))
        REG_WINDOW_MIN:   d[15:0] = c.window_min;
        REG_INVERSE_SPAN: d = c.inverse_span;
        REG_FLAT_WINDOW:  d[0] = c.flat_window;
        REG_BRIGHTNESS:   d[20:0] = c.brightness_offset;
        REG_CONTRAST:     d = c.contrast_gain;
        REG_ADJUST_EN:    d[0] = c.adjust_enable;
        REG_GAMMA_EN:     d[0] = c.gamma_enable;
        REG_PALETTE_LAST: d[7:0] = c.palette_last;
        default: ;
      endcase
      write_reg(cfg_reg_t'(k), d);
    end
    map_cfg = c;
  endtask

  task automatic settle();
    while (req_backlog.size() != 0 || in_tvalid || colors_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_map(logic [15:0] smp);
    req_t q;
    q.op = OP_MAP;
    q.sample = smp;
    q.eidx = IDX_W'($urandom);
    q.eval = $urandom;
    req_backlog.push_back(q);
  endtask

  task automatic queue_write(logic [1:0] op, logic [IDX_W-1:0] ix, logic [VAL_W-1:0] v);
    req_t q;
    q.op = op;
    q.sample = 16'($urandom);
    q.eidx = ix;
    q.eval = v;
    req_backlog.push_back(q);
  endtask

  function automatic int pick_gap();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 13;
      default: return $urandom_range(1, 13);
    endcase
  endfunction

  function automatic void pick_random_cfg(output cfg_t c, output int span);
    int shift, b;
    shift = $urandom_range(0, 16);
    span = $urandom_range(1, (shift == 16) ? 65535 : (1 << shift));
    c.window_min = 16'($urandom);
    if ($urandom_range(0, 3) != 0) c.inverse_span = 24'(65536 / span + $urandom_range(0, 3));
    else c.inverse_span = 24'($urandom);
    c.flat_window = ($urandom_range(0, 7) == 0);
    b = int'($urandom_range(0, 32768)) - 16384;
    if ($urandom_range(0, 2) != 0) c.brightness_offset = b[20:0];
    else c.brightness_offset = 21'($urandom);
    if ($urandom_range(0, 2) != 0) c.contrast_gain = 24'($urandom_range(0, 4 * ONE_Q16));
    else c.contrast_gain = 24'($urandom);
    c.adjust_enable = 1'($urandom_range(0, 1));
    c.gamma_enable = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 5))
      0:       c.palette_last = 8'd0;
      1:       c.palette_last = 8'd255;
      default: c.palette_last = 8'($urandom);
    endcase
  endfunction

  initial begin : stimulus
    cfg_t c;
    int   span, k;
    map_cfg = '{window_min: 16'd0, inverse_span: 24'd2, flat_window: 1'b0,
                brightness_offset: 21'd0, contrast_gain: 24'(ONE_Q16),
                adjust_enable: 1'b0, gamma_enable: 1'b0, palette_last: 8'd255};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // fill both tables under reset settings
    in_gap_max = 3;
    out_gap_max = 3;
    for (int i = 0; i < PAL_DEPTH; i++) queue_write(OP_PAL, IDX_W'(i), $urandom);
    for (int i = 0; i < GAM_DEPTH; i++) queue_write(OP_GAMMA, IDX_W'(i), $urandom);
    queue_map(16'h8000);
    queue_map(16'h7fff);
    queue_map(16'h0000);
    queue_write(OP_PAL, 10'd256, 32'hdeadbeef);
    queue_write(OP_PAL, 10'd1023, 32'hffffffff);
    queue_write(OP_UNUSED, 10'd5, 32'h12345678);
    queue_map(16'h0001);
    settle();

    // saturation with adjust on
    c = '{window_min: 16'h8000, inverse_span: 24'hffffff, flat_window: 1'b0,
          brightness_offset: 21'h100000, contrast_gain: 24'hffffff,
          adjust_enable: 1'b1, gamma_enable: 1'b0, palette_last: 8'd255};
    load_config(c);
    queue_map(16'h7fff);
    queue_map(16'h8000);
    settle();

    // saturation with adjust off
    c.window_min = 16'h7fff;
    c.adjust_enable = 1'b0;
    c.brightness_offset = 21'h0fffff;
    load_config(c);
    queue_map(16'h8000);
    queue_map(16'h7fff);
    settle();

    // flat window, palette entry zero rewritten mid-stream
    c.flat_window = 1'b1;
    load_config(c);
    queue_map(16'h04d2);
    queue_write(OP_PAL, 10'd0, 32'ha5a55a5a);
    queue_map(16'hffff);
    settle();

    // gamma with clamping below zero and above one
    c = '{window_min: 16'd0, inverse_span: 24'd655, flat_window: 1'b0,
          brightness_offset: 21'd0, contrast_gain: 24'(ONE_Q16),
          adjust_enable: 1'b1, gamma_enable: 1'b1, palette_last: 8'd128};
    load_config(c);
    queue_map(16'hfffb);
    queue_map(16'd0);
    queue_map(16'd50);
    queue_map(16'd100);
    queue_map(16'd200);
    settle();

    // half-up rounding on a two-entry palette
    c.adjust_enable = 1'b0;
    c.gamma_enable = 1'b0;
    c.inverse_span = 24'(HALF_Q16);
    c.palette_last = 8'd1;
    load_config(c);
    queue_map(16'd0);
    queue_map(16'd1);
    queue_map(16'd2);
    queue_map(16'd3);
    queue_map(16'hffff);
    settle();

    // single-entry palette, full brightness, zero contrast
    c.adjust_enable = 1'b1;
    c.brightness_offset = 21'h0fffff;
    c.contrast_gain = 24'd0;
    c.palette_last = 8'd0;
    load_config(c);
    queue_map(16'd100);
    queue_map(16'hff9c);
    settle();

    for (int p = 0; p < RAND_PHASES; p++) begin
      pick_random_cfg(c, span);
      load_config(c);
      in_gap_max = pick_gap();
      out_gap_max = pick_gap();
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        k = $urandom_range(0, 19);
        if (k < 15) begin
          if ($urandom_range(0, 3) != 0) queue_map(16'(c.window_min + $urandom_range(0, span)));
          else queue_map(16'($urandom));
        end else if (k < 17) begin
          if ($urandom_range(0, 1) != 0) queue_write(OP_PAL, IDX_W'($urandom), $urandom);
          else queue_write(OP_PAL, IDX_W'($urandom_range(0, PAL_DEPTH - 1)), $urandom);
        end else if (k < 19) begin
          queue_write(OP_GAMMA, IDX_W'($urandom), $urandom);
        end else begin
          queue_write(OP_UNUSED, IDX_W'($urandom), $urandom);
        end
      end
      settle();
    end

    if (err_count == 0 && colors_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
